// ===== hw/rtl/first_fit_aligned_segment_allocator_defines.svh =====
// Assertion macros for the first fit aligned segment allocator.
// Included by the files that assert; expects clk and arst_n in scope.
`ifndef FIRST_FIT_ALIGNED_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ALIGNED_SEGMENT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define FFAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define FFAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ffas_pkg.sv =====
// Shared types and codes of the segment allocator.
// No dependencies.
package ffas_pkg;

	localparam int DW = 32;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_RESP
	} state_t;

	// Result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOFIT   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_OVERLAP = 3'd3;
	localparam logic [2:0] ST_SMALL   = 3'd4;

	// Request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Per-entry evaluation from the shared step unit
	typedef struct packed {
		logic          hit;     // alloc fits this entry
		logic          drop;    // aligned exact fit, entry goes away
		logic          split;   // unaligned fit leaving a tail entry
		logic [DW-1:0] w_start; // entry as written back
		logic [DW-1:0] w_len;
		logic [DW-1:0] t_start; // tail entry
		logic [DW-1:0] t_len;
		logic [DW-1:0] grant;
		logic          ovl;     // free overlaps this entry
		logic          after;   // entry starts above the freed address
	} step_t;

endpackage

// ===== hw/rtl/ffas_table.sv =====
// Double-banked segment table: one write and one registered read per cycle.
// Depends on ffas_pkg.
module ffas_table
	import ffas_pkg::*;
#(
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_start,
	output logic [DW-1:0] rd_len,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_start,
	input  logic [DW-1:0] wr_len
);

	logic [DW-1:0] mem_start [2**AW];
	logic [DW-1:0] mem_len   [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_addr] <= wr_start;
			mem_len[wr_addr]   <= wr_len;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start <= mem_start[rd_addr];
			rd_len   <= mem_len[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/ffas_step.sv =====
// Shared step unit: evaluates one table entry against the current request.
// Depends on ffas_pkg.
module ffas_step
	import ffas_pkg::*;
(
	input  logic [DW-1:0] e_start,
	input  logic [DW-1:0] e_len,
	input  logic [DW-1:0] size,
	input  logic [DW-1:0] mask,
	input  logic [DW-1:0] addr,
	input  logic [DW:0]   req_end,
	output step_t         res
);

	logic [DW:0] e_end;
	logic [DW:0] bound;
	logic [DW:0] gap;
	logic [DW:0] asz;
	logic        aligned;
	logic        ua_ok;

	// aligned boundary and the room left behind it
	always_comb begin
		e_end   = {1'b0, e_start} + {1'b0, e_len};
		aligned = (e_start & mask) == '0;
		bound   = {1'b0, e_start & ~mask} + {1'b0, mask} + {{DW{1'b0}}, 1'b1};
		gap     = bound - {1'b0, e_start};
		asz     = {1'b0, e_len} - gap;
		ua_ok   = (gap < {1'b0, e_len}) && (asz >= {1'b0, size});
	end

	// fit decision and the entries written back
	always_comb begin
		res.hit   = (e_len >= size) && (aligned || ua_ok);
		res.drop  = aligned && (e_len == size);
		res.split = !aligned && (asz != {1'b0, size});
		res.grant = aligned ? e_start : bound[DW-1:0];
		res.t_start = bound[DW-1:0] + size;
		res.t_len   = asz[DW-1:0] - size;
		res.w_start = e_start;
		res.w_len   = e_len;
		if (res.hit) begin
			if (aligned) begin
				res.w_start = e_start + size;
				res.w_len   = e_len - size;
			end else if (res.split) begin
				res.w_len = gap[DW-1:0];
			end else begin
				res.w_len = e_len - size;
			end
		end
		res.ovl   = ({1'b0, addr} < e_end) && ({1'b0, e_start} < req_end);
		res.after = e_start > addr;
	end

endmodule

// ===== hw/rtl/first_fit_aligned_segment_allocator.sv =====
// One request at a time: s_tready is high only while idle, and the next request is taken
// once the result has been accepted. A free rejected up front (shorter than MIN_SEGMENT or
// running past the address space) skips the table scan. The single step unit checks one
// entry a cycle, but holds while a split entry's tail is written or a freed segment is put in.
// arst_n clears the control state and empties the table; table contents need no reset.
module first_fit_aligned_segment_allocator
	import ffas_pkg::*;
#(
	parameter int MAX_SEGMENTS = 16,
	parameter int MIN_SEGMENT  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // seg_address[31:0], seg_length[63:32], align_log2[68:64]
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // granted_address[31:0], status[34:32], free_total[66:35]
);

	`include "first_fit_aligned_segment_allocator_defines.svh"

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int WW = $clog2(MAX_SEGMENTS + 2);

	state_t state_q, state_n;

	logic          bank_q, bank_n;
	logic [CW-1:0] used_q, used_n;
	logic [DW-1:0] free_sum_q, free_sum_n;
	logic          type_q, type_n;
	logic [DW-1:0] addr_q, addr_n;
	logic [DW-1:0] len_q, len_n;
	logic [DW-1:0] mask_q, mask_n;
	logic [DW:0]   end_q, end_n;
	logic [CW-1:0] rd_idx_q, rd_idx_n;
	logic          dv_q, dv_n;
	logic [WW-1:0] wr_cnt_q, wr_cnt_n;
	logic          found_q, found_n;
	logic          placed_q, placed_n;
	logic          pend_vld_q, pend_vld_n;
	logic [DW-1:0] pend_s_q, pend_s_n;
	logic [DW-1:0] pend_l_q, pend_l_n;
	logic          tail_q, tail_n;
	logic [DW-1:0] tail_s_q, tail_s_n;
	logic [DW-1:0] tail_l_q, tail_l_n;
	logic [DW-1:0] grant_q, grant_n;
	logic [2:0]    status_q, status_n;

	logic          ren, consume, adv;
	logic          early_rej, abort, scan_done;
	logic          wr_en;
	logic [WW-1:0] wr_pos;
	logic [DW-1:0] wr_s, wr_l;
	logic          em_do;
	logic [DW-1:0] em_s, em_l;
	logic [DW:0]   pend_end;
	logic [WW-1:0] m_cnt;
	logic [DW-1:0] e_start, e_len;
	logic [DW-1:0] in_addr, in_len;
	logic [4:0]    in_align;
	logic [DW:0]   in_end;
	step_t         st;

	assign in_addr  = s_tdata[31:0];
	assign in_len   = s_tdata[63:32];
	assign in_align = s_tdata[68:64];
	assign in_end   = {1'b0, in_addr} + {1'b0, in_len};
	assign pend_end = {1'b0, pend_s_q} + {1'b0, pend_l_q};
	assign m_cnt    = wr_cnt_q + {{(WW-1){1'b0}}, 1'b1};

	ffas_table #(.AW(IW + 1)) u_table (
		.clk      (clk),
		.rd_en    (ren),
		.rd_addr  ({bank_q, rd_idx_q[IW-1:0]}),
		.rd_start (e_start),
		.rd_len   (e_len),
		.wr_en    (wr_en),
		.wr_addr  ({~bank_q, wr_pos[IW-1:0]}),
		.wr_start (wr_s),
		.wr_len   (wr_l)
	);

	ffas_step u_step (
		.e_start (e_start),
		.e_len   (e_len),
		.size    (len_q),
		.mask    (mask_q),
		.addr    (addr_q),
		.req_end (end_q),
		.res     (st)
	);

	// request datapath and table rewrite
	always_comb begin
		bank_n     = bank_q;
		used_n     = used_q;
		free_sum_n = free_sum_q;
		type_n     = type_q;
		addr_n     = addr_q;
		len_n      = len_q;
		mask_n     = mask_q;
		end_n      = end_q;
		wr_cnt_n   = wr_cnt_q;
		found_n    = found_q;
		placed_n   = placed_q;
		pend_vld_n = pend_vld_q;
		pend_s_n   = pend_s_q;
		pend_l_n   = pend_l_q;
		tail_n     = tail_q;
		tail_s_n   = tail_s_q;
		tail_l_n   = tail_l_q;
		grant_n    = grant_q;
		status_n   = status_q;
		consume    = 1'b0;
		early_rej  = 1'b0;
		abort      = 1'b0;
		wr_en      = 1'b0;
		wr_pos     = wr_cnt_q;
		wr_s       = '0;
		wr_l       = '0;
		em_do      = 1'b0;
		em_s       = '0;
		em_l       = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					type_n     = s_tuser;
					addr_n     = in_addr;
					len_n      = in_len;
					mask_n     = (32'd1 << in_align) - 32'd1;
					end_n      = in_end;
					wr_cnt_n   = '0;
					found_n    = 1'b0;
					placed_n   = 1'b0;
					pend_vld_n = 1'b0;
					tail_n     = 1'b0;
					grant_n    = '0;
					status_n   = ST_OK;
					if (s_tuser == REQ_FREE) begin
						if (in_len < DW'(MIN_SEGMENT)) begin
							early_rej = 1'b1;
							status_n  = ST_SMALL;
						end else if (in_end[DW]) begin
							early_rej = 1'b1;
							status_n  = ST_OVERLAP;
						end
					end
				end
			end
			S_SCAN: begin
				if (type_q == REQ_ALLOC) begin
					if (tail_q) begin
						// second write of a split entry
						wr_en    = 1'b1;
						wr_s     = tail_s_q;
						wr_l     = tail_l_q;
						wr_cnt_n = wr_cnt_q + WW'(1);
						tail_n   = 1'b0;
					end else if (dv_q) begin
						consume = 1'b1;
						if (!found_q && st.hit && st.split &&
							used_q >= CW'(MAX_SEGMENTS)) begin
							abort    = 1'b1;
							status_n = ST_FULL;
						end else if (!found_q && st.hit) begin
							found_n = 1'b1;
							grant_n = st.grant;
							if (!st.drop) begin
								wr_en    = 1'b1;
								wr_s     = st.w_start;
								wr_l     = st.w_len;
								wr_cnt_n = wr_cnt_q + WW'(1);
							end
							tail_n   = st.split;
							tail_s_n = st.t_start;
							tail_l_n = st.t_len;
						end else begin
							wr_en    = 1'b1;
							wr_s     = e_start;
							wr_l     = e_len;
							wr_cnt_n = wr_cnt_q + WW'(1);
						end
					end
				end else if (dv_q) begin
					if (st.ovl) begin
						abort    = 1'b1;
						status_n = ST_OVERLAP;
					end else if (!placed_q && st.after) begin
						// freed segment goes ahead of this entry
						em_do    = 1'b1;
						em_s     = addr_q;
						em_l     = len_q;
						placed_n = 1'b1;
					end else begin
						em_do   = 1'b1;
						em_s    = e_start;
						em_l    = e_len;
						consume = 1'b1;
					end
				end
			end
			S_FIN: begin
				if (type_q == REQ_ALLOC) begin
					if (found_q) begin
						bank_n     = ~bank_q;
						used_n     = wr_cnt_q[CW-1:0];
						free_sum_n = free_sum_q - len_q;
					end else begin
						status_n = ST_NOFIT;
						grant_n  = '0;
					end
				end else if (!placed_q) begin
					em_do    = 1'b1;
					em_s     = addr_q;
					em_l     = len_q;
					placed_n = 1'b1;
				end else begin
					// flush the pending merged entry and commit
					wr_en = wr_cnt_q < WW'(MAX_SEGMENTS);
					wr_s  = pend_s_q;
					wr_l  = pend_l_q;
					if (m_cnt > WW'(MAX_SEGMENTS)) begin
						status_n = ST_FULL;
					end else begin
						bank_n     = ~bank_q;
						used_n     = m_cnt[CW-1:0];
						free_sum_n = free_sum_q + len_q;
					end
				end
			end
			default: begin
			end
		endcase

		// merge stream for free: extend the pending entry or write it out
		if (em_do) begin
			if (pend_vld_q && pend_end == {1'b0, em_s}) begin
				pend_l_n = pend_l_q + em_l;
			end else begin
				if (pend_vld_q) begin
					wr_en    = wr_cnt_q < WW'(MAX_SEGMENTS);
					wr_s     = pend_s_q;
					wr_l     = pend_l_q;
					wr_cnt_n = wr_cnt_q + WW'(1);
				end
				pend_vld_n = 1'b1;
				pend_s_n   = em_s;
				pend_l_n   = em_l;
			end
		end
	end

	// read-ahead: fetch the next entry as soon as the current one is used
	always_comb begin
		adv       = !dv_q || consume;
		ren       = (state_q == S_SCAN) && !tail_q && !abort && adv && (rd_idx_q < used_q);
		rd_idx_n  = (state_q == S_IDLE) ? '0 : rd_idx_q + CW'(ren);
		dv_n      = (state_q == S_IDLE) ? 1'b0 : (ren ? 1'b1 : (adv ? 1'b0 : dv_q));
		scan_done = !dv_q && !tail_q && (rd_idx_q == used_q);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_n = early_rej ? S_RESP : S_SCAN;
				end
			end
			S_SCAN: begin
				if (abort) begin
					state_n = S_RESP;
				end else if (scan_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (type_q == REQ_ALLOC || placed_q) begin
					state_n = S_RESP;
				end
			end
			S_RESP: begin
				if (m_tready) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// port outputs
	always_comb begin
		s_tready = state_q == S_IDLE;
		m_tvalid = state_q == S_RESP;
		m_tdata  = {5'd0, free_sum_q, status_q, grant_q};
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bank_q     <= 1'b0;
			used_q     <= '0;
			free_sum_q <= '0;
			rd_idx_q   <= '0;
			dv_q       <= 1'b0;
			wr_cnt_q   <= '0;
			found_q    <= 1'b0;
			placed_q   <= 1'b0;
			pend_vld_q <= 1'b0;
			tail_q     <= 1'b0;
		end else begin
			state_q    <= state_n;
			bank_q     <= bank_n;
			used_q     <= used_n;
			free_sum_q <= free_sum_n;
			rd_idx_q   <= rd_idx_n;
			dv_q       <= dv_n;
			wr_cnt_q   <= wr_cnt_n;
			found_q    <= found_n;
			placed_q   <= placed_n;
			pend_vld_q <= pend_vld_n;
			tail_q     <= tail_n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		type_q   <= type_n;
		addr_q   <= addr_n;
		len_q    <= len_n;
		mask_q   <= mask_n;
		end_q    <= end_n;
		pend_s_q <= pend_s_n;
		pend_l_q <= pend_l_n;
		tail_s_q <= tail_s_n;
		tail_l_q <= tail_l_n;
		grant_q  <= grant_n;
		status_q <= status_n;
	end

	`FFAS_ASSERT_NOW(a_one_side, m_tvalid, !s_tready, "result pending while taking a request")
	`FFAS_ASSERT_NOW(a_used_bound, 1'b1, used_q <= CW'(MAX_SEGMENTS), "table count past depth")
	`FFAS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"ready right after a transaction")
	`FFAS_ASSERT_NOW(a_scan_read_bound, state_q == S_SCAN, rd_idx_q <= used_q,
		"read index past table count")

endmodule

// ===== dv/tb_first_fit_aligned_segment_allocator.sv =====
// Testbench for the first fit aligned segment allocator: drives alloc and free
// requests on the stream input and checks every result against a local predictor.
// Depends on ffas_pkg and the first_fit_aligned_segment_allocator RTL.
module tb_first_fit_aligned_segment_allocator;
	import ffas_pkg::*;

	localparam int NSEG = 16;
	localparam int MINSEG = 8;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [31:0] grant;
		logic [2:0]  status;
		logic [31:0] total;
	} result_t;

	// Scoreboard: free-list predictor plus queue of expected results
	class alloc_scoreboard;
		logic [31:0] seg_base[NSEG];
		logic [31:0] seg_len[NSEG];
		int          seg_cnt;
		logic [31:0] bytes_free;
		result_t     pending[$];
		int          errors;

		function new();
			seg_cnt = 0;
			bytes_free = 0;
			errors = 0;
		endfunction

		function logic [2:0] predict_free(logic [31:0] addr, logic [31:0] len);
			logic [32:0] ts[NSEG+1], tl[NSEG+1], ms[NSEG+1], ml[NSEG+1];
			logic [32:0] fin;
			int n, m;
			bit placed;
			n = 0;
			m = 0;
			placed = 0;
			fin = {1'b0, addr} + {1'b0, len};
			if (len < MINSEG) return ST_SMALL;
			if (fin > 33'h0_FFFF_FFFF) return ST_OVERLAP;
			for (int i = 0; i < seg_cnt; i++)
				if ({1'b0, addr} < {1'b0, seg_base[i]} + {1'b0, seg_len[i]}
						&& {1'b0, seg_base[i]} < fin)
					return ST_OVERLAP;
			for (int i = 0; i < seg_cnt; i++) begin
				if (!placed && seg_base[i] > addr) begin
					ts[n] = {1'b0, addr}; tl[n] = {1'b0, len}; n++; placed = 1;
				end
				ts[n] = {1'b0, seg_base[i]}; tl[n] = {1'b0, seg_len[i]}; n++;
			end
			if (!placed) begin
				ts[n] = {1'b0, addr}; tl[n] = {1'b0, len}; n++;
			end
			// coalesce adjacent neighbors
			for (int i = 0; i < n; i++) begin
				if (m > 0 && ms[m-1] + ml[m-1] == ts[i]) ml[m-1] += tl[i];
				else begin
					ms[m] = ts[i]; ml[m] = tl[i]; m++;
				end
			end
			if (m > NSEG) return ST_FULL;
			for (int i = 0; i < m; i++) begin
				seg_base[i] = ms[i][31:0];
				seg_len[i] = ml[i][31:0];
			end
			seg_cnt = m;
			bytes_free += len;
			return ST_OK;
		endfunction

		function logic [2:0] predict_alloc(logic [31:0] size, logic [4:0] align,
				output logic [31:0] grant);
			logic [32:0] mask, base, len, abnd, asz;
			mask = (33'd1 << align) - 33'd1;
			grant = 0;
			for (int i = 0; i < seg_cnt; i++) begin
				base = {1'b0, seg_base[i]};
				len = {1'b0, seg_len[i]};
				if (len < {1'b0, size}) continue;
				if ((base & mask) == 0) begin
					if (len == {1'b0, size}) begin
						for (int j = i; j + 1 < seg_cnt; j++) begin
							seg_base[j] = seg_base[j+1];
							seg_len[j] = seg_len[j+1];
						end
						seg_cnt--;
					end else begin
						seg_base[i] = 32'(base + {1'b0, size});
						seg_len[i] = 32'(len - {1'b0, size});
					end
					grant = base[31:0];
					bytes_free -= size;
					return ST_OK;
				end
				abnd = (base & ~mask) + mask + 33'd1;
				if (abnd - base >= len) continue;
				asz = len - (abnd - base);
				if (asz < {1'b0, size}) continue;
				if (asz == {1'b0, size}) seg_len[i] = 32'(len - {1'b0, size});
				else begin
					if (seg_cnt >= NSEG) return ST_FULL;
					for (int j = seg_cnt; j > i + 1; j--) begin
						seg_base[j] = seg_base[j-1];
						seg_len[j] = seg_len[j-1];
					end
					seg_base[i+1] = 32'(abnd + {1'b0, size});
					seg_len[i+1] = 32'(asz - {1'b0, size});
					seg_len[i] = 32'(abnd - base);
					seg_cnt++;
				end
				grant = abnd[31:0];
				bytes_free -= size;
				return ST_OK;
			end
			return ST_NOFIT;
		endfunction

		// Note an accepted request and queue its expected result
		function void note_request(logic kind, logic [31:0] addr, logic [31:0] len,
				logic [4:0] align);
			result_t r;
			logic [31:0] g;
			g = 0;
			if (kind == REQ_FREE) r.status = predict_free(addr, len);
			else r.status = predict_alloc(len, align, g);
			r.grant = g;
			r.total = bytes_free;
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.grant !== want.grant || got.status !== want.status
					|| got.total !== want.total) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: grant %h/%h status %0d/%0d total %h/%h",
						want.grant, got.grant, want.status, got.status,
						want.total, got.total);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // seg_address, seg_length, align_log2
	logic        s_tuser;  // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // granted_address, status, free_total

	alloc_scoreboard sb;
	int  idle_pct;
	int  quiet_cycles;

	first_fit_aligned_segment_allocator u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Input transactions go to the predictor, output transactions to the checker
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[68:64]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tdata[31:0], m_tdata[34:32], m_tdata[66:35]});
	end

	// Random result backpressure
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Valid drops only during random idle cycles; held high while waiting for ready
	task automatic send(logic kind, logic [31:0] addr, logic [31:0] len, logic [4:0] align);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b0, align, len, addr};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic free_seg(logic [31:0] addr, logic [31:0] len);
		send(REQ_FREE, addr, len, 5'($urandom));
	endtask

	task automatic alloc_seg(logic [31:0] len, logic [4:0] align);
		send(REQ_ALLOC, $urandom, len, align);
	endtask

	initial begin
		logic [31:0] a, l;
		int k;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = REQ_ALLOC;
		s_tdata = '0;
		m_tready = 1'b0;
		quiet_cycles = 0;
		idle_pct = 22;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, size and address extremes, alignment extremes
		alloc_seg(32'h0, 5'd0);
		free_seg(32'h1000, 32'd7);
		free_seg(32'hFFFF_FFF8, 32'd8);
		free_seg(32'hFFFF_FFF0, 32'd15);
		free_seg(32'h0, 32'h10);
		free_seg(32'h8, 32'h10);
		free_seg(32'h1003, 32'h100);
		alloc_seg(32'h10, 5'd4);
		alloc_seg(32'h0, 5'd3);
		alloc_seg(32'h20, 5'd8);
		alloc_seg(32'h0, 5'd8);
		free_seg(32'h10, 32'hFF3);
		free_seg(32'h8000_0000, 32'h7FFF_FFFF);
		alloc_seg(32'h10, 5'd31);
		alloc_seg(32'hFFFF_FFFF, 5'd0);
		alloc_seg(32'h1000, 5'd31);
		free_seg(32'h0, 32'h10);
		for (int i = 0; i < 18; i++) free_seg(32'h100000 + 32'(i * 64), 32'd32);
		alloc_seg(32'd8, 5'd2);

		// random: frees of random ranges in a low window and anywhere, allocs
		for (int i = 0; i < 400; i++) begin
			if (i == 150) idle_pct = 0;
			if (i == 250) idle_pct = 22;
			k = $urandom_range(9);
			if (k < 4) begin
				l = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
				alloc_seg(l, 5'(($urandom_range(4) == 0) ? $urandom : $urandom_range(6)));
			end else if (k < 8) begin
				a = ($urandom_range(255) << 12) + $urandom_range(4095);
				free_seg(a, $urandom_range(600));
			end else free_seg($urandom, $urandom);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
